// File: src/owpd_pkg.sv
// shared types and constants for the one-wire pulse-width decoder
// used by every module of the block; no dependencies
package owpd_pkg;

    localparam int COUNT_WIDTH_DEF = 12;
    localparam int MAX_BYTES_DEF   = 256;

    localparam int TIMEOUT_W   = 12;
    localparam int BYTE_W      = 8;
    localparam int BYTE_NUM_W  = 9;
    localparam int BIT_POS_W   = 3;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 12'd2000;
    localparam logic [BYTE_W-1:0]    FIRST_BIT     = 8'h80;

    // result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    // configuration register index (paddr[2])
    localparam logic REG_IDLE_TIMEOUT = 1'b0;

    // classified line sample handed from front to back
    typedef struct packed {
        logic falling;
        logic level;
    } t_sample;

    typedef struct packed {
        logic                  kind;
        logic [BYTE_W-1:0]     rx_byte;
        logic [BYTE_NUM_W-1:0] byte_number;
    } t_result;

endpackage

// File: src/owpd_front.sv
// front end: takes line samples and marks falling edges
// depends on owpd_pkg
module owpd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_level,
    output logic              o_ready,
    output logic              o_push,
    output owpd_pkg::t_sample o_sample,
    input  logic              i_full
);
    import owpd_pkg::*;

    logic r_prev_level;
    logic n_prev_level;

    assign o_ready          = !i_full;
    assign o_push           = i_valid && !i_full;
    assign o_sample.level   = i_level;
    assign o_sample.falling = r_prev_level && !i_level;

    always_comb begin
        n_prev_level = r_prev_level;
        if (o_push) begin
            n_prev_level = i_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b1;
        end else begin
            r_prev_level <= n_prev_level;
        end
    end

endmodule

// File: src/owpd_queue.sv
// two-entry queue of classified samples between front and back
// depends on owpd_pkg
module owpd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  owpd_pkg::t_sample i_sample,
    output logic              o_full,
    output logic              o_valid,
    output owpd_pkg::t_sample o_sample,
    input  logic              i_pop
);
    import owpd_pkg::*;

    t_sample    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       w_pop;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_sample = r_mem[r_rd_ptr];
    assign w_pop    = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (w_pop) begin
            n_rd_ptr = !r_rd_ptr;
        end
        case ({i_push, w_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: src/owpd_back.sv
// back end: bit-cell counting, bit decode, byte assembly and result register
// depends on owpd_pkg
module owpd_back #(
    parameter int COUNT_WIDTH = owpd_pkg::COUNT_WIDTH_DEF,
    parameter int MAX_BYTES   = owpd_pkg::MAX_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [owpd_pkg::TIMEOUT_W-1:0]     i_timeout,
    input  logic                               i_item_valid,
    input  owpd_pkg::t_sample                  i_item,
    output logic                               o_item_ready,
    output logic                               o_valid,
    output owpd_pkg::t_result                  o_result,
    input  logic                               i_ready
);
    import owpd_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic                   r_active;
    logic [COUNT_WIDTH-1:0] r_low;
    logic [COUNT_WIDTH-1:0] r_high;
    logic [BYTE_W-1:0]      r_byte;
    logic [BIT_POS_W-1:0]   r_bit_pos;
    logic [BYTE_NUM_W-1:0]  r_bytes;
    logic                   r_out_valid;
    t_result                r_out;

    logic                   n_active;
    logic [COUNT_WIDTH-1:0] n_low;
    logic [COUNT_WIDTH-1:0] n_high;
    logic [BYTE_W-1:0]      n_byte;
    logic [BIT_POS_W-1:0]   n_bit_pos;
    logic [BYTE_NUM_W-1:0]  n_bytes;
    logic                   n_out_valid;
    t_result                n_out;

    logic                   w_take;
    logic [COUNT_WIDTH-1:0] w_low_t;
    logic [COUNT_WIDTH-1:0] w_high_t;
    logic [COUNT_WIDTH-1:0] w_high_inc;
    logic [BYTE_W-1:0]      w_byte_bit;

    assign o_item_ready = !r_out_valid || i_ready;
    assign w_take       = i_item_valid && o_item_ready;
    assign o_valid      = r_out_valid;
    assign o_result     = r_out;

    // a falling edge closes the cell, so counters restart from zero
    assign w_low_t    = i_item.falling ? '0 : r_low;
    assign w_high_t   = i_item.falling ? '0 : r_high;
    assign w_high_inc = (w_high_t == CNT_MAX) ? w_high_t : w_high_t + 1'b1;
    assign w_byte_bit = (i_item.falling && (r_high > r_low))
                        ? (FIRST_BIT >> r_bit_pos) : '0;

    always_comb begin
        n_active    = r_active;
        n_low       = r_low;
        n_high      = r_high;
        n_byte      = r_byte;
        n_bit_pos   = r_bit_pos;
        n_bytes     = r_bytes;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        if (w_take) begin
            if (!r_active) begin
                if (i_item.falling) begin
                    n_active  = 1'b1;
                    n_low     = COUNT_WIDTH'(1);
                    n_high    = '0;
                    n_byte    = '0;
                    n_bit_pos = '0;
                    n_bytes   = '0;
                end
            end else begin
                n_low  = w_low_t;
                n_high = w_high_t;
                if (i_item.falling) begin
                    if (r_bit_pos == BIT_POS_W'(7)) begin
                        if (r_bytes < BYTE_NUM_W'(MAX_BYTES)) begin
                            n_out_valid       = 1'b1;
                            n_out.kind        = KIND_DATA;
                            n_out.rx_byte     = r_byte | w_byte_bit;
                            n_out.byte_number = r_bytes;
                            n_bytes           = r_bytes + 1'b1;
                        end
                        n_byte    = '0;
                        n_bit_pos = '0;
                    end else begin
                        n_byte    = r_byte | w_byte_bit;
                        n_bit_pos = r_bit_pos + 1'b1;
                    end
                end
                if (!i_item.level) begin
                    n_low = (w_low_t == CNT_MAX) ? w_low_t : w_low_t + 1'b1;
                end else begin
                    n_high = w_high_inc;
                    if (CMP_W'(w_high_inc) > CMP_W'(i_timeout)) begin
                        // end of frame, partial byte dropped
                        n_out_valid       = 1'b1;
                        n_out.kind        = KIND_EOF;
                        n_out.rx_byte     = '0;
                        n_out.byte_number = r_bytes;
                        n_active          = 1'b0;
                        n_low             = '0;
                        n_high            = '0;
                        n_byte            = '0;
                        n_bit_pos         = '0;
                        n_bytes           = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_low       <= '0;
            r_high      <= '0;
            r_byte      <= '0;
            r_bit_pos   <= '0;
            r_bytes     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_low       <= n_low;
            r_high      <= n_high;
            r_byte      <= n_byte;
            r_bit_pos   <= n_bit_pos;
            r_bytes     <= n_bytes;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTH
    a_eof_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_EOF) |-> (r_out.rx_byte == '0))
        else $error("end of frame result carries a nonzero byte");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_low == '0 && r_high == '0 && r_byte == '0
                       && r_bit_pos == '0 && r_bytes == '0))
        else $error("frame state not clear while idle");

    a_bytes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes <= BYTE_NUM_W'(MAX_BYTES))
        else $error("byte count beyond limit");

    a_no_take_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result overwritten");
`endif

endmodule

// File: src/one_wire_pulse_width_decoder.sv
// top level of the one-wire pulse-width decoder: config register and wiring
// depends on owpd_pkg, owpd_front, owpd_queue, owpd_back
//
// usage:
//   slave stream: one line sample per transfer, tdata[0] = line level.
//   master stream: one result per finished byte (up to MAX_BYTES per frame) or per end of frame;
//     tuser[0] = kind (0 data byte, 1 end of frame), tdata[7:0] = byte
//     (zero at end of frame), tdata[16:8] = byte index or frame byte count.
//   apb: idle_timeout at byte address 0 (12 bits, reset 2000); write only
//     while the block is idle.
// timing: a sample can be taken every cycle while the queue has room; it passes the
//   queue and then the output register before its result shows on the master side,
//   and the block sustains one sample per cycle while the master side keeps up.
// the front edge detector feeds a two-entry queue, the back decoder drains it
//   and holds each result in an output register; when the master stalls the
//   back end stops and the queue fills, then tready drops.
// reset: synchronous, active low; the line is taken as idle high, no frame is
//   open, the queue and output register are empty.
module one_wire_pulse_width_decoder #(
    parameter int COUNT_WIDTH = owpd_pkg::COUNT_WIDTH_DEF,
    parameter int MAX_BYTES   = owpd_pkg::MAX_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] line_level
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] rx_byte, [16:8] byte_number, zeros above
    output logic [0:0]  o_m_tuser,   // [0] result_kind
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import owpd_pkg::*;

    logic [TIMEOUT_W-1:0] r_timeout;
    logic                 w_cfg_wr;
    logic                 w_push;
    logic                 w_full;
    t_sample              w_push_sample;
    logic                 w_q_valid;
    t_sample              w_q_sample;
    logic                 w_pop;
    t_result              w_result;

    assign o_pready = 1'b1;
    assign w_cfg_wr = i_psel && i_penable && i_pwrite && o_pready;
    assign o_prdata = (i_paddr[2] == REG_IDLE_TIMEOUT) ? 32'(r_timeout) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (w_cfg_wr && i_paddr[2] == REG_IDLE_TIMEOUT) begin
            r_timeout <= i_pwdata[TIMEOUT_W-1:0];
        end
    end

    owpd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_level  (i_s_tdata[0]),
        .o_ready  (o_s_tready),
        .o_push   (w_push),
        .o_sample (w_push_sample),
        .i_full   (w_full)
    );

    owpd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_sample (w_push_sample),
        .o_full   (w_full),
        .o_valid  (w_q_valid),
        .o_sample (w_q_sample),
        .i_pop    (w_pop)
    );

    owpd_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .MAX_BYTES   (MAX_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_timeout    (r_timeout),
        .i_item_valid (w_q_valid),
        .i_item       (w_q_sample),
        .o_item_ready (w_pop),
        .o_valid      (o_m_tvalid),
        .o_result     (w_result),
        .i_ready      (i_m_tready)
    );

    assign o_m_tdata = {7'd0, w_result.byte_number, w_result.rx_byte};
    assign o_m_tuser = w_result.kind;

endmodule
